// ===== sv/vcsrl_pkg.sv =====
`timescale 1ns / 1ps
package vcsrl_pkg;

  localparam int NUM_PORTS_DEF   = 16;
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int PORT_FIELD_W    = 4;
  localparam int TIME_W          = 64;
  localparam int LIMIT_W         = 32;
  localparam int OUT_COUNT_W     = 32;

  localparam logic [2:0] OP_OPEN    = 3'd0;
  localparam logic [2:0] OP_SUCCESS = 3'd1;
  localparam logic [2:0] OP_FAILURE = 3'd2;
  localparam logic [2:0] OP_DESTROY = 3'd3;
  localparam logic [2:0] OP_LIMIT   = 3'd4;
  localparam logic [2:0] OP_QUERY   = 3'd5;
  localparam logic [2:0] OP_SET     = 3'd6;
  localparam logic [2:0] OP_RSVD    = 3'd7;

  localparam logic [1:0] MODE_INVALID = 2'd3;

  localparam logic [1:0] STAT_DONE     = 2'd0;
  localparam logic [1:0] STAT_DISABLED = 2'd1;
  localparam logic [1:0] STAT_INVALID  = 2'd2;

  typedef struct packed {
    logic [2:0]              operation;
    logic [PORT_FIELD_W-1:0] port_index;
    logic [1:0]              transport_mode;
    logic [TIME_W-1:0]       now_time;
    logic [LIMIT_W-1:0]      new_max_count;
    logic [TIME_W-1:0]       new_window_length;
  } in_word_t;

  typedef struct packed {
    logic [1:0]             status;
    logic                   refused;
    logic [OUT_COUNT_W-1:0] established_out;
    logic [OUT_COUNT_W-1:0] active_out;
    logic [OUT_COUNT_W-1:0] failed_out;
    logic [OUT_COUNT_W-1:0] opening_out;
  } out_word_t;

  typedef enum logic [1:0] {
    CTL_CLEAR,
    CTL_IDLE,
    CTL_EXEC
  } ctl_state_t;

  typedef struct packed {
    logic clr;
    logic load;
    logic exec;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
  } dp_sts_t;

endpackage

// ===== sv/vcsrl_ctrl.sv =====
`timescale 1ns / 1ps
module vcsrl_ctrl
  import vcsrl_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CTL_CLEAR: begin
        if (sts.clr_last) begin
          state_nxt = CTL_IDLE;
        end
      end
      CTL_IDLE: begin
        if (in_valid) begin
          state_nxt = CTL_EXEC;
        end
      end
      CTL_EXEC: begin
        if (slot_free) begin
          state_nxt = CTL_IDLE;
        end
      end
      default: state_nxt = CTL_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      CTL_CLEAR: begin
        cmd.clr = 1'b1;
      end
      CTL_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      CTL_EXEC: begin
        cmd.exec = slot_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= CTL_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== sv/vcsrl_dp.sv =====
`timescale 1ns / 1ps
module vcsrl_dp
  import vcsrl_pkg::*;
#(
  parameter int NUM_PORTS   = NUM_PORTS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data,
  input  in_word_t  in_data,
  output out_word_t out_data,
  input  dp_cmd_t   cmd,
  output dp_sts_t   sts
);

  localparam int PORTS_USED = (NUM_PORTS < (1 << PORT_FIELD_W)) ? NUM_PORTS
                                                                 : (1 << PORT_FIELD_W);
  localparam int PORT_AW = (PORTS_USED > 1) ? $clog2(PORTS_USED) : 1;
  localparam int AW      = PORT_AW + 2;
  localparam int ENTRIES = 1 << AW;
  localparam int PDEPTH  = 1 << PORT_AW;
  localparam int CMP_W   = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] established;
    logic [COUNT_WIDTH-1:0] active;
    logic [COUNT_WIDTH-1:0] failed;
    logic [COUNT_WIDTH-1:0] opening;
    logic [TIME_W-1:0]      window_end;
    logic [COUNT_WIDTH-1:0] admissions;
    logic [LIMIT_W-1:0]     limit;
  } entry_t;

  entry_t            ent_mem [ENTRIES];
  logic [TIME_W-1:0] len_mem [PDEPTH];

  entry_t            ent_rd_r;
  logic [TIME_W-1:0] len_rd_r;
  in_word_t          item_r;
  out_word_t         out_data_r;
  logic              enable_r;
  logic [AW-1:0]     clr_addr_r, clr_addr_nxt;

  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      item_addr;
  logic [AW-1:0]      ent_wr_addr;
  entry_t             ent_wr_data;
  logic               ent_wr_en;
  logic [PORT_AW-1:0] len_wr_addr;
  logic [TIME_W-1:0]  len_wr_data;
  logic               len_wr_en;

  entry_t    ent_new;
  out_word_t res;
  logic      disabled;
  logic      invalid;
  logic      port_oor;
  logic      item_ok;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
    sat_inc = (&c) ? c : c + 1'b1;
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] floor_dec(input logic [COUNT_WIDTH-1:0] c);
    floor_dec = (c == '0) ? c : c - 1'b1;
  endfunction

  assign rd_addr   = {in_data.port_index[PORT_AW-1:0], in_data.transport_mode};
  assign item_addr = {item_r.port_index[PORT_AW-1:0], item_r.transport_mode};

  assign port_oor = {1'b0, item_r.port_index} >= (PORT_FIELD_W + 1)'(PORTS_USED);
  assign disabled = (item_r.operation <= OP_LIMIT) && !enable_r;
  assign invalid  = (item_r.operation == OP_RSVD) || (item_r.transport_mode == MODE_INVALID)
                    || port_oor;
  assign item_ok  = !disabled && !invalid;

  always_comb begin
    ent_new = ent_rd_r;
    res     = '0;
    if (disabled) begin
      res.status = STAT_DISABLED;
    end else if (invalid) begin
      res.status = STAT_INVALID;
    end else begin
      res.status = STAT_DONE;
      unique case (item_r.operation)
        OP_OPEN: begin
          ent_new.opening    = sat_inc(ent_rd_r.opening);
          ent_new.admissions = sat_inc(ent_rd_r.admissions);
        end
        OP_SUCCESS: begin
          ent_new.opening     = floor_dec(ent_rd_r.opening);
          ent_new.established = sat_inc(ent_rd_r.established);
          ent_new.active      = sat_inc(ent_rd_r.active);
        end
        OP_FAILURE: begin
          ent_new.opening = floor_dec(ent_rd_r.opening);
          ent_new.failed  = sat_inc(ent_rd_r.failed);
        end
        OP_DESTROY: begin
          ent_new.active = floor_dec(ent_rd_r.active);
        end
        OP_LIMIT: begin
          if (ent_rd_r.limit != '0 && len_rd_r != '0) begin
            if (ent_rd_r.window_end < item_r.now_time) begin
              ent_new.window_end = item_r.now_time + len_rd_r;
              ent_new.admissions = '0;
            end else begin
              res.refused = CMP_W'(ent_rd_r.admissions) >= CMP_W'(ent_rd_r.limit);
            end
          end
        end
        OP_QUERY: begin
          res.established_out = OUT_COUNT_W'(ent_rd_r.established);
          res.active_out      = OUT_COUNT_W'(ent_rd_r.active);
          res.failed_out      = OUT_COUNT_W'(ent_rd_r.failed);
          res.opening_out     = OUT_COUNT_W'(ent_rd_r.opening);
        end
        OP_SET: begin
          ent_new.limit = item_r.new_max_count;
        end
        default: begin
          ent_new = ent_rd_r;
        end
      endcase
    end
  end

  always_comb begin
    if (cmd.clr) begin
      ent_wr_en   = 1'b1;
      ent_wr_addr = clr_addr_r;
      ent_wr_data = '0;
      len_wr_en   = 1'b1;
      len_wr_addr = clr_addr_r[AW-1:2];
      len_wr_data = '0;
    end else begin
      ent_wr_en   = cmd.exec && item_ok;
      ent_wr_addr = item_addr;
      ent_wr_data = ent_new;
      len_wr_en   = cmd.exec && item_ok && (item_r.operation == OP_SET);
      len_wr_addr = item_r.port_index[PORT_AW-1:0];
      len_wr_data = item_r.new_window_length;
    end
  end

  always_ff @(posedge clk) begin
    if (ent_wr_en) begin
      ent_mem[ent_wr_addr] <= ent_wr_data;
    end
    if (cmd.load) begin
      ent_rd_r <= ent_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (len_wr_en) begin
      len_mem[len_wr_addr] <= len_wr_data;
    end
    if (cmd.load) begin
      len_rd_r <= len_mem[in_data.port_index[PORT_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
    if (cmd.exec) begin
      out_data_r <= res;
    end
  end

  assign clr_addr_nxt = cmd.clr ? clr_addr_r + 1'b1 : clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= 1'b0;
      clr_addr_r <= '0;
    end else begin
      clr_addr_r <= clr_addr_nxt;
      if (cfg_wr_en) begin
        enable_r <= cfg_wr_data;
      end
    end
  end

  assign sts.clr_last = &clr_addr_r;
  assign out_data     = out_data_r;

endmodule

// ===== sv/vport_connection_stats_rate_limit.sv =====
`timescale 1ns / 1ps
// Each accepted input word is registered with its statistics entry; the result word is then
// registered once the output slot is free. A new input word is taken only after the result
// of the last one has been registered, since each word reads and writes back one statistics
// entry in the entry memory. Reset: synchronous, active low; afterwards a clearing pass
// zeroes the memories while no input word is taken.
module vport_connection_stats_rate_limit
  import vcsrl_pkg::*;
#(
  parameter int NUM_PORTS   = NUM_PORTS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  vcsrl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  vcsrl_dp #(
    .NUM_PORTS   (NUM_PORTS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .out_data    (out_data),
    .cmd         (cmd),
    .sts         (sts)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> ##1 out_valid)
    else $error("no result after accepted word");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == STAT_DONE || out_data.status == STAT_DISABLED ||
                   out_data.status == STAT_INVALID))
    else $error("undefined status code");

  a_refused_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.refused |-> out_data.status == STAT_DONE)
    else $error("refusal with non-done status");

endmodule

// ===== dv/vport_stats_monitor.sv =====
`timescale 1ns / 1ps
module vport_stats_monitor
  import vcsrl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_word_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_word_t out_data,
  output int        errors,
  output int        pending
);

  localparam int ENTRIES = NUM_PORTS_DEF * 3;
  localparam logic [COUNT_WIDTH_DEF-1:0] COUNT_TOP = '1;

  logic [COUNT_WIDTH_DEF-1:0] est_cnt    [ENTRIES];
  logic [COUNT_WIDTH_DEF-1:0] act_cnt    [ENTRIES];
  logic [COUNT_WIDTH_DEF-1:0] fail_cnt   [ENTRIES];
  logic [COUNT_WIDTH_DEF-1:0] open_cnt   [ENTRIES];
  logic [COUNT_WIDTH_DEF-1:0] admit_cnt  [ENTRIES];
  logic [TIME_W-1:0]          win_end    [ENTRIES];
  logic [LIMIT_W-1:0]         admit_max  [ENTRIES];
  logic [TIME_W-1:0]          win_len    [NUM_PORTS_DEF];
  logic                       stats_on;
  out_word_t                  predicted_replies[$];

  function automatic logic [COUNT_WIDTH_DEF-1:0] sat_up(input logic [COUNT_WIDTH_DEF-1:0] v);
    return (v == COUNT_TOP) ? v : v + 1'b1;
  endfunction

  function automatic logic [COUNT_WIDTH_DEF-1:0] floor_down(
    input logic [COUNT_WIDTH_DEF-1:0] v);
    return (v == '0) ? v : v - 1'b1;
  endfunction

  task automatic apply_word(input in_word_t w, output out_word_t r);
    int e;
    int p;
    r = '0;
    p = w.port_index;
    if (w.operation <= OP_LIMIT && !stats_on) begin
      r.status = STAT_DISABLED;
    end else if (w.operation == OP_RSVD || w.transport_mode == MODE_INVALID ||
                 p >= NUM_PORTS_DEF) begin
      r.status = STAT_INVALID;
    end else begin
      e = p * 3 + int'(w.transport_mode);
      r.status = STAT_DONE;
      case (w.operation)
        OP_OPEN: begin
          open_cnt[e]  = sat_up(open_cnt[e]);
          admit_cnt[e] = sat_up(admit_cnt[e]);
        end
        OP_SUCCESS: begin
          open_cnt[e] = floor_down(open_cnt[e]);
          est_cnt[e]  = sat_up(est_cnt[e]);
          act_cnt[e]  = sat_up(act_cnt[e]);
        end
        OP_FAILURE: begin
          open_cnt[e] = floor_down(open_cnt[e]);
          fail_cnt[e] = sat_up(fail_cnt[e]);
        end
        OP_DESTROY: begin
          act_cnt[e] = floor_down(act_cnt[e]);
        end
        OP_LIMIT: begin
          if (admit_max[e] != '0 && win_len[p] != '0) begin
            if (win_end[e] < w.now_time) begin
              win_end[e]   = w.now_time + win_len[p];
              admit_cnt[e] = '0;
            end else if (admit_cnt[e] >= admit_max[e]) begin
              r.refused = 1'b1;
            end
          end
        end
        OP_QUERY: begin
          r.established_out = est_cnt[e][OUT_COUNT_W-1:0];
          r.active_out      = act_cnt[e][OUT_COUNT_W-1:0];
          r.failed_out      = fail_cnt[e][OUT_COUNT_W-1:0];
          r.opening_out     = open_cnt[e][OUT_COUNT_W-1:0];
        end
        OP_SET: begin
          admit_max[e] = w.new_max_count;
          win_len[p]   = w.new_window_length;
        end
        default: begin
        end
      endcase
    end
  endtask

  task automatic report_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    out_word_t want;
    out_word_t reply;
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        est_cnt[i]   = '0;
        act_cnt[i]   = '0;
        fail_cnt[i]  = '0;
        open_cnt[i]  = '0;
        admit_cnt[i] = '0;
        win_end[i]   = '0;
        admit_max[i] = '0;
      end
      for (int i = 0; i < NUM_PORTS_DEF; i++) begin
        win_len[i] = '0;
      end
      stats_on = 1'b0;
      errors   = 0;
      predicted_replies.delete();
    end else begin
      if (cfg_wr_en) begin
        stats_on = cfg_wr_data;
      end
      if (out_valid && out_ready) begin
        if (predicted_replies.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual 0x%0h", $time,
                   out_data);
          errors++;
        end else begin
          want = predicted_replies.pop_front();
          report_field("status", want.status, out_data.status);
          report_field("refused", want.refused, out_data.refused);
          report_field("established_out", want.established_out, out_data.established_out);
          report_field("active_out", want.active_out, out_data.active_out);
          report_field("failed_out", want.failed_out, out_data.failed_out);
          report_field("opening_out", want.opening_out, out_data.opening_out);
        end
      end
      if (in_valid && in_ready) begin
        apply_word(in_data, reply);
        predicted_replies.push_back(reply);
      end
    end
    pending = predicted_replies.size();
  end

endmodule

// ===== dv/vport_connection_stats_rate_limit_tb.sv =====
`timescale 1ns / 1ps
module vport_connection_stats_rate_limit_tb;
  import vcsrl_pkg::*;

  localparam logic [1:0] MODE_RM = 2'd0;
  localparam logic [1:0] MODE_RC = 2'd1;
  localparam logic [1:0] MODE_UM = 2'd2;
  localparam logic [63:0] TIME_TOP = '1;

  logic      clk;
  logic      rst_n;
  logic      cfg_wr_en;
  logic      cfg_wr_data;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;
  int        errors_seen;
  int        replies_owed;
  bit        no_idle;
  logic [63:0] sim_now;

  vport_connection_stats_rate_limit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  vport_stats_monitor monitor (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .errors     (errors_seen),
    .pending    (replies_owed)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #12_000_000;
    $display("vport_connection_stats_rate_limit regression: fail");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (no_idle || r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(3, 1);
    end
    return $urandom_range(40, 6);
  endfunction

  function automatic in_word_t stats_word(input logic [2:0] op, input logic [3:0] port,
                                          input logic [1:0] mode, input logic [63:0] now,
                                          input logic [31:0] max_cnt,
                                          input logic [63:0] len);
    in_word_t w;
    w.operation         = op;
    w.port_index        = port;
    w.transport_mode    = mode;
    w.now_time          = now;
    w.new_max_count     = max_cnt;
    w.new_window_length = len;
    return w;
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    int r;
    r = $urandom_range(99);
    if (r < 30) w.operation = OP_OPEN;
    else if (r < 45) w.operation = OP_SUCCESS;
    else if (r < 55) w.operation = OP_FAILURE;
    else if (r < 65) w.operation = OP_DESTROY;
    else if (r < 82) w.operation = OP_LIMIT;
    else if (r < 92) w.operation = OP_QUERY;
    else if (r < 97) w.operation = OP_SET;
    else w.operation = OP_RSVD;
    w.port_index     = ($urandom_range(99) < 80) ? 4'($urandom_range(3))
                                                 : 4'($urandom_range(15));
    w.transport_mode = ($urandom_range(99) < 94) ? 2'($urandom_range(2)) : MODE_INVALID;
    w.now_time       = {$urandom, $urandom};
    w.new_max_count  = $urandom;
    w.new_window_length = {$urandom, $urandom};
    if (w.operation == OP_LIMIT && $urandom_range(99) < 97) begin
      sim_now    = sim_now + 64'($urandom_range(30));
      w.now_time = sim_now;
    end
    if (w.operation == OP_SET) begin
      r = $urandom_range(99);
      if (r < 70) w.new_max_count = $urandom_range(6, 1);
      else if (r < 80) w.new_max_count = '0;
      r = $urandom_range(99);
      if (r < 70) w.new_window_length = 64'($urandom_range(100, 1));
      else if (r < 80) w.new_window_length = '0;
    end
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (replies_owed != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_enable(input logic v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) begin
      send_word(random_word());
    end
  endtask

  initial begin
    int hold;
    out_ready = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold == 0) begin
        out_ready <= 1'b1;
        hold = pick_gap();
      end else begin
        out_ready <= 1'b0;
        hold--;
      end
    end
  end

  initial begin
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    no_idle     = 1'b0;
    sim_now     = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Statistics are off after reset: events and rate-limit checks are ignored, query and set still work.
    send_word(stats_word(OP_OPEN, 4'd0, MODE_RM, '0, '0, '0));
    send_word(stats_word(OP_LIMIT, 4'd0, MODE_RM, '0, '0, '0));
    send_word(stats_word(OP_OPEN, 4'd1, MODE_INVALID, '0, '0, '0));
    send_word(stats_word(OP_QUERY, 4'd0, MODE_RM, '0, '0, '0));
    send_word(stats_word(OP_SET, 4'd2, MODE_UM, '0, 32'd3, 64'd10));
    send_word(stats_word(OP_RSVD, 4'd0, MODE_RM, '0, '0, '0));
    drain();
    set_enable(1'b1);

    send_word(stats_word(OP_SET, 4'd0, MODE_RM, '0, 32'd2, 64'd100));
    send_word(stats_word(OP_LIMIT, 4'd0, MODE_RM, 64'd0, '0, '0));
    send_word(stats_word(OP_OPEN, 4'd0, MODE_RM, '0, '0, '0));
    send_word(stats_word(OP_OPEN, 4'd0, MODE_RM, '0, '0, '0));
    send_word(stats_word(OP_LIMIT, 4'd0, MODE_RM, 64'd50, '0, '0));
    send_word(stats_word(OP_OPEN, 4'd0, MODE_RM, '0, '0, '0));
    send_word(stats_word(OP_OPEN, 4'd0, MODE_RM, '0, '0, '0));
    send_word(stats_word(OP_LIMIT, 4'd0, MODE_RM, 64'd150, '0, '0));
    send_word(stats_word(OP_SUCCESS, 4'd0, MODE_RM, '0, '0, '0));
    send_word(stats_word(OP_FAILURE, 4'd0, MODE_RM, '0, '0, '0));
    send_word(stats_word(OP_FAILURE, 4'd0, MODE_RM, '0, '0, '0));
    send_word(stats_word(OP_DESTROY, 4'd0, MODE_RM, '0, '0, '0));
    send_word(stats_word(OP_DESTROY, 4'd0, MODE_RM, '0, '0, '0));
    send_word(stats_word(OP_QUERY, 4'd0, MODE_RM, '0, '0, '0));
    send_word(stats_word(OP_SET, 4'd0, MODE_INVALID, '0, '0, '0));
    send_word(stats_word(OP_LIMIT, 4'd0, MODE_RM, 64'd150, '0, '0));
    send_word(stats_word(OP_QUERY, 4'd15, MODE_INVALID, '0, '0, '0));
    send_word(stats_word(OP_RSVD, 4'd15, MODE_RC, TIME_TOP, '1, TIME_TOP));
    send_word(stats_word(OP_SET, 4'd15, MODE_UM, '0, '1, TIME_TOP));
    send_word(stats_word(OP_LIMIT, 4'd15, MODE_UM, TIME_TOP, '0, '0));
    send_word(stats_word(OP_SET, 4'd2, MODE_UM, '0, '0, 64'd5));
    send_word(stats_word(OP_OPEN, 4'd2, MODE_UM, '0, '0, '0));
    send_word(stats_word(OP_LIMIT, 4'd2, MODE_UM, 64'd1, '0, '0));

    run_random(175);
    drain();
    run_random(175);
    drain();

    set_enable(1'b0);
    run_random(150);
    drain();

    set_enable(1'b1);
    no_idle = 1'b1;
    run_random(200);
    drain();
    no_idle = 1'b0;
    run_random(200);
    drain();

    if (errors_seen == 0) begin
      $display("vport_connection_stats_rate_limit regression: pass");
    end else begin
      $display("vport_connection_stats_rate_limit regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/vcsrl_pkg.sv
sv/vcsrl_ctrl.sv
sv/vcsrl_dp.sv
sv/vport_connection_stats_rate_limit.sv
dv/vport_stats_monitor.sv
dv/vport_connection_stats_rate_limit_tb.sv
